// ===== hdl/fixed_capacity_list_engine_assert.svh =====
// Assertion macros shared by the list engine RTL.
`ifndef FIXED_CAPACITY_LIST_ENGINE_ASSERT_SVH
`define FIXED_CAPACITY_LIST_ENGINE_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled during reset.
`define FCL_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled during reset.
`define FCL_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FCL_ASSERT_IMP(lbl, ante, cons, msg)
`define FCL_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hdl/fcl_pkg.sv =====
// Types and constants of the fixed capacity list engine.
package fcl_pkg;

    localparam int MODE_W    = 4;
    localparam int VALUE_W   = 32;
    localparam int POS_W     = 7;
    localparam int SLOT_W    = 6;
    localparam int LEN_W     = 7;
    localparam int STATUS_W  = 2;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 80;

    typedef enum logic [3:0] {
        MODE_CLEAR     = 4'd0,
        MODE_INS_FIRST = 4'd1,
        MODE_INS_LAST  = 4'd2,
        MODE_INS_AT    = 4'd3,
        MODE_DEL_FIRST = 4'd4,
        MODE_DEL_LAST  = 4'd5,
        MODE_DEL_AT    = 4'd6,
        MODE_FIND      = 4'd7,
        MODE_EXTREMES  = 4'd8,
        MODE_SORT_UP   = 4'd9,
        MODE_SORT_DOWN = 4'd10
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADPOS = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ACT_HOLD,
        ACT_ROTATE,
        ACT_OPEN_RIGHT,
        ACT_OPEN_LEFT,
        ACT_CLOSE,
        ACT_LOAD,
        ACT_SORT
    } act_t;

    typedef struct packed {
        act_t act;
        logic phase;
        logic desc;
    } cell_ctrl_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY,
        S_SORT,
        S_HOLD
    } state_t;

endpackage

// ===== hdl/fcl_cell.sv =====
// One slot of the list store with its neighbour moves.
module fcl_cell #(
    parameter int IW  = 6,
    parameter int EW  = 32,
    parameter int IDX = 0
) (
    input  logic                   clk,
    input  fcl_pkg::cell_ctrl_t    ctrl,
    input  logic [IW-1:0]          lo,
    input  logic [IW-1:0]          hi,
    input  logic signed [EW-1:0]   value,
    input  logic signed [EW-1:0]   left_q,
    input  logic signed [EW-1:0]   right_q,
    output logic signed [EW-1:0]   q
);

    localparam logic [IW-1:0] ME  = IW'(IDX);
    localparam logic          PAR = ((IDX % 2) == 1);

    logic signed [EW-1:0] q_reg;
    logic signed [EW-1:0] q_next;
    logic                 lt_r;
    logic                 lt_l;

    assign lt_r = q_reg < right_q;
    assign lt_l = left_q < q_reg;

    always_comb
    begin
        q_next = q_reg;
        case (ctrl.act)
            fcl_pkg::ACT_ROTATE:
            begin
                q_next = right_q;
            end
            fcl_pkg::ACT_OPEN_RIGHT:
            begin
                if (ME == lo)
                    q_next = value;
                else if (ME > lo && ME <= hi)
                    q_next = left_q;
            end
            fcl_pkg::ACT_OPEN_LEFT:
            begin
                if (ME == hi)
                    q_next = value;
                else if (ME >= lo && ME < hi)
                    q_next = right_q;
            end
            fcl_pkg::ACT_CLOSE:
            begin
                if (ME >= lo && ME < hi)
                    q_next = right_q;
            end
            fcl_pkg::ACT_LOAD:
            begin
                if (ME == lo)
                    q_next = value;
            end
            fcl_pkg::ACT_SORT:
            begin
                // left member of a pair keeps the lower (or upper) of the two
                if (PAR == ctrl.phase && ME >= lo && ME < hi)
                    q_next = (lt_r ^ ctrl.desc) ? q_reg : right_q;
                else if (PAR != ctrl.phase && ME > lo && ME <= hi)
                    q_next = (lt_l ^ ctrl.desc) ? q_reg : left_q;
            end
            default:
            begin
                q_next = q_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

// ===== hdl/fixed_capacity_list_engine.sv =====
// Top level of the fixed capacity list engine: command sequencer and cell row.
//
//  Channel | Dir | Width | Contents
//  s_*     | in  | 48    | command request: mode, value, position
//  m_*     | out | 80    | result: data_out, largest, found, slot_index, length, status
//
//  One request at a time. Every command rotates the cell row once round to
//  scan it, then applies its change in S_APPLY and hands the result over
//  from S_HOLD. Sorts of two or more elements add an odd-even exchange pass
//  (S_SORT) between apply and handover. The next request is taken while a result waits
//  in the output register; a stalled result holds the sequencer before handover.
//  Reset clears first slot, count and handshake state; the store is unset.
`include "fixed_capacity_list_engine_assert.svh"
module fixed_capacity_list_engine #(
    parameter int CAPACITY_SLOTS = 64,
    parameter int ELEM_WIDTH     = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // mode[3:0], value[35:4], position[42:36], zero fill
    input  logic [fcl_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // data_out[31:0], largest[63:32], found[64], slot_index[70:65],
    // length[77:71], status[79:78]
    output logic [fcl_pkg::M_TDATA_W-1:0]     m_tdata
);

    localparam int CAP = CAPACITY_SLOTS;
    localparam int EW  = ELEM_WIDTH;
    localparam int IW  = $clog2(CAP);
    localparam int CW  = $clog2(CAP + 1);
    localparam int XW  = ((CW + 1) > fcl_pkg::POS_W ? (CW + 1) : fcl_pkg::POS_W) + 1;

    fcl_pkg::state_t      state_reg, state_next;
    fcl_pkg::mode_t       mode_reg;
    logic signed [EW-1:0] val_reg;
    logic [fcl_pkg::POS_W-1:0] pos_reg;
    logic [IW-1:0]        first_reg, first_a;
    logic [CW-1:0]        count_reg, count_a;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 cnt_last;

    logic                 fnd_reg;
    logic [IW-1:0]        si_reg;
    logic signed [EW-1:0] min_reg, max_reg, del_reg;

    fcl_pkg::status_t     res_status;
    logic [CW-1:0]        res_len;
    logic signed [EW-1:0] res_data, res_large;
    logic                 res_found;
    logic [IW-1:0]        res_si;

    logic                 m_tvalid_reg;
    logic [fcl_pkg::M_TDATA_W-1:0] out_reg;

    fcl_pkg::act_t        act_a;
    fcl_pkg::status_t     st_a;
    logic [IW-1:0]        lo_a, hi_a, cell_lo, cell_hi;
    fcl_pkg::cell_ctrl_t  ctrl;

    logic [XW-1:0]        first_x, count_x, pos_x, last_x, k_x, ins_p, del_p;
    logic                 full, empty, in_run, accept, handover;
    logic signed [EW-1:0] head;
    logic signed [EW-1:0] cell_q [CAP];

    assign accept   = s_tvalid && s_tready;
    assign handover = (state_reg == fcl_pkg::S_HOLD) && (!m_tvalid_reg || m_tready);
    assign cnt_last = (cnt_reg == CW'(CAP - 1));

    assign first_x = XW'(first_reg);
    assign count_x = XW'(count_reg);
    assign pos_x   = XW'(pos_reg);
    assign k_x     = XW'(cnt_reg);
    assign last_x  = first_x + count_x - XW'(1);
    assign full    = (count_reg == CW'(CAP));
    assign empty   = (count_reg == '0);
    assign in_run  = (k_x >= first_x) && (k_x < first_x + count_x);
    assign head    = cell_q[0];

    always_comb
    begin
        case (mode_reg)
            fcl_pkg::MODE_INS_FIRST: ins_p = '0;
            fcl_pkg::MODE_INS_LAST:  ins_p = count_x;
            default:                 ins_p = pos_x;
        endcase
        case (mode_reg)
            fcl_pkg::MODE_DEL_FIRST: del_p = '0;
            fcl_pkg::MODE_DEL_LAST:  del_p = count_x - XW'(1);
            default:                 del_p = pos_x;
        endcase
    end

    // decode the command against the current run
    always_comb
    begin
        act_a   = fcl_pkg::ACT_HOLD;
        lo_a    = '0;
        hi_a    = '0;
        first_a = first_reg;
        count_a = count_reg;
        st_a    = fcl_pkg::ST_OK;
        case (mode_reg)
            fcl_pkg::MODE_CLEAR:
            begin
                first_a = '0;
                count_a = '0;
            end
            fcl_pkg::MODE_INS_FIRST, fcl_pkg::MODE_INS_LAST, fcl_pkg::MODE_INS_AT:
            begin
                if (full)
                    st_a = fcl_pkg::ST_FULL;
                else if (empty)
                begin
                    if (mode_reg == fcl_pkg::MODE_INS_AT && pos_reg != '0)
                        st_a = fcl_pkg::ST_BADPOS;
                    else
                    begin
                        act_a   = fcl_pkg::ACT_LOAD;
                        first_a = '0;
                        count_a = CW'(1);
                    end
                end
                else if (mode_reg == fcl_pkg::MODE_INS_AT && pos_x > count_x)
                    st_a = fcl_pkg::ST_BADPOS;
                else if (last_x != XW'(CAP - 1))
                begin
                    act_a   = fcl_pkg::ACT_OPEN_RIGHT;
                    lo_a    = IW'(first_x + ins_p);
                    hi_a    = IW'(last_x + XW'(1));
                    count_a = count_reg + CW'(1);
                end
                else
                begin
                    act_a   = fcl_pkg::ACT_OPEN_LEFT;
                    lo_a    = IW'(first_x - XW'(1));
                    hi_a    = IW'(first_x + ins_p - XW'(1));
                    first_a = first_reg - IW'(1);
                    count_a = count_reg + CW'(1);
                end
            end
            fcl_pkg::MODE_DEL_FIRST, fcl_pkg::MODE_DEL_LAST, fcl_pkg::MODE_DEL_AT:
            begin
                if (empty)
                    st_a = fcl_pkg::ST_EMPTY;
                else if (mode_reg == fcl_pkg::MODE_DEL_AT && pos_x >= count_x)
                    st_a = fcl_pkg::ST_BADPOS;
                else
                begin
                    act_a   = fcl_pkg::ACT_CLOSE;
                    lo_a    = IW'(first_x + del_p);
                    hi_a    = IW'(last_x);
                    count_a = count_reg - CW'(1);
                    if (count_reg == CW'(1))
                        first_a = '0;
                end
            end
            fcl_pkg::MODE_FIND, fcl_pkg::MODE_EXTREMES:
            begin
                if (empty)
                    st_a = fcl_pkg::ST_EMPTY;
            end
            default:
            begin
                st_a = fcl_pkg::ST_OK;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fcl_pkg::S_IDLE:
                if (s_tvalid)
                    state_next = fcl_pkg::S_SCAN;
            fcl_pkg::S_SCAN:
                if (cnt_last)
                    state_next = fcl_pkg::S_APPLY;
            fcl_pkg::S_APPLY:
                if ((mode_reg == fcl_pkg::MODE_SORT_UP || mode_reg == fcl_pkg::MODE_SORT_DOWN)
                    && count_reg >= CW'(2))
                    state_next = fcl_pkg::S_SORT;
                else
                    state_next = fcl_pkg::S_HOLD;
            fcl_pkg::S_SORT:
                if (cnt_last)
                    state_next = fcl_pkg::S_HOLD;
            fcl_pkg::S_HOLD:
                if (handover)
                    state_next = fcl_pkg::S_IDLE;
            default:
                state_next = fcl_pkg::S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        s_tready   = 1'b0;
        ctrl.act   = fcl_pkg::ACT_HOLD;
        ctrl.phase = cnt_reg[0];
        ctrl.desc  = (mode_reg == fcl_pkg::MODE_SORT_DOWN);
        cell_lo    = lo_a;
        cell_hi    = hi_a;
        cnt_next   = '0;
        case (state_reg)
            fcl_pkg::S_IDLE:
                s_tready = 1'b1;
            fcl_pkg::S_SCAN:
            begin
                ctrl.act = fcl_pkg::ACT_ROTATE;
                cnt_next = cnt_last ? '0 : cnt_reg + CW'(1);
            end
            fcl_pkg::S_APPLY:
                ctrl.act = act_a;
            fcl_pkg::S_SORT:
            begin
                ctrl.act = fcl_pkg::ACT_SORT;
                cell_lo  = first_reg;
                cell_hi  = IW'(last_x);
                cnt_next = cnt_last ? '0 : cnt_reg + CW'(1);
            end
            default:
                s_tready = 1'b0;
        endcase
    end

    genvar g;
    generate
        for (g = 0; g < CAP; g++)
        begin : g_cell
            localparam int LI = (g == 0) ? 0 : g - 1;
            localparam int RI = (g == CAP - 1) ? 0 : g + 1;
            fcl_cell #(
                .IW  (IW),
                .EW  (EW),
                .IDX (g)
            ) u_cell (
                .clk     (clk),
                .ctrl    (ctrl),
                .lo      (cell_lo),
                .hi      (cell_hi),
                .value   (val_reg),
                .left_q  (cell_q[LI]),
                .right_q (cell_q[RI]),
                .q       (cell_q[g])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= fcl_pkg::S_IDLE;
            cnt_reg      <= '0;
            first_reg    <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (state_reg == fcl_pkg::S_APPLY)
            begin
                first_reg <= first_a;
                count_reg <= count_a;
            end
            if (handover)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // request capture, scan accumulators and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= fcl_pkg::mode_t'(s_tdata[3:0]);
            val_reg  <= EW'($signed(s_tdata[35:4]));
            pos_reg  <= s_tdata[42:36];
            fnd_reg  <= 1'b0;
            si_reg   <= '0;
            min_reg  <= '0;
            max_reg  <= '0;
            del_reg  <= '0;
        end
        if (state_reg == fcl_pkg::S_SCAN)
        begin
            if (mode_reg == fcl_pkg::MODE_FIND && in_run && !fnd_reg && head == val_reg)
            begin
                fnd_reg <= 1'b1;
                si_reg  <= cnt_reg[IW-1:0];
            end
            if (mode_reg == fcl_pkg::MODE_EXTREMES && in_run)
            begin
                if (k_x == first_x)
                begin
                    min_reg <= head;
                    max_reg <= head;
                end
                else
                begin
                    if (head < min_reg)
                        min_reg <= head;
                    if (max_reg < head)
                        max_reg <= head;
                end
            end
            if (k_x == first_x + del_p)
                del_reg <= head;
        end
        if (state_reg == fcl_pkg::S_APPLY)
        begin
            res_status <= st_a;
            res_len    <= count_a;
            res_found  <= fnd_reg;
            res_si     <= si_reg;
            res_data   <= '0;
            res_large  <= '0;
            if (act_a == fcl_pkg::ACT_CLOSE)
                res_data <= del_reg;
            else if (mode_reg == fcl_pkg::MODE_EXTREMES && !empty)
            begin
                res_data  <= min_reg;
                res_large <= max_reg;
            end
        end
        if (handover)
            out_reg <= {res_status, fcl_pkg::LEN_W'(res_len), fcl_pkg::SLOT_W'(res_si),
                        res_found, fcl_pkg::VALUE_W'(res_large),
                        fcl_pkg::VALUE_W'(res_data)};
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg;

    `FCL_ASSERT_IMP(a_count_cap, count_reg != '0, count_reg <= CW'(CAP), "count above capacity")
    `FCL_ASSERT_IMP(a_empty_at_zero, count_reg == '0, first_reg == '0, "empty run not at slot 0")
    `FCL_ASSERT_NXT(a_accept_scan, accept, state_reg == fcl_pkg::S_SCAN, "request did not start scan")
    `FCL_ASSERT_NXT(a_hold_stall, state_reg == fcl_pkg::S_HOLD && m_tvalid_reg && !m_tready, state_reg == fcl_pkg::S_HOLD, "result left hold while output stalled")

endmodule
